### sv/rotation_matrix_to_quaternion_unit_defines.svh
// Assertion macros for the rotation matrix to quaternion unit.
// Needs a clock named clk and a reset named rst in the including scope.
`ifndef ROTATION_MATRIX_TO_QUATERNION_UNIT_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_UNIT_DEFINES_SVH

// Same-cycle implication, off during reset.
`define RMQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rmq check failed");

// Next-cycle implication, off during reset.
`define RMQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rmq check failed");

`endif

### sv/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion unit.
// No dependencies.
`default_nettype none
package rmq_pkg;

  localparam int ONE         = 16384;
  localparam int QMAX        = 16384;
  localparam int MAG_W       = 17;   // |term| < 2^17
  localparam int SQ_W        = 34;
  localparam int SUM_W       = 36;
  localparam int VAL_W       = 60;   // sum << 24
  localparam int ROOT_W      = 30;
  localparam int REM_W       = 32;
  localparam int NUM_W       = 45;
  localparam int QUO_W       = 16;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int OUT_DEPTH_DEF   = 2;

  typedef enum logic [1:0] {BR_TRACE, BR_X, BR_Y, BR_Z} branch_t;

  typedef struct packed {
    logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  } in_t;

  typedef struct packed {
    logic signed [15:0] q_x, q_y, q_z, q_w;
    logic               degenerate;
  } out_t;

  // Raw terms as sign and magnitude, lane 0..3 = x, y, z, w
  typedef struct packed {
    logic [3:0]             neg;
    logic [3:0][MAG_W-1:0]  mag;
  } term_t;

endpackage
`default_nettype wire

### sv/rmq_fifo.sv
// Small first-in first-out queue built from flops.
// Generic width and depth; no package use.
`default_nettype none
module rmq_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      dout,
  output logic              empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wr, rd;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd];

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      count <= '0;
    end else begin
      if (do_push) wr <= (wr == PW'(DEPTH - 1)) ? '0 : wr + 1'b1;
      if (do_pop)  rd <= (rd == PW'(DEPTH - 1)) ? '0 : rd + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  // store word
  always_ff @(posedge clk) begin
    if (do_push) mem[wr] <= din;
  end
endmodule
`default_nettype wire

### sv/rmq_front.sv
// Front end: takes a matrix word, picks the branch, forms the four raw terms.
// Depends on rmq_pkg.
`default_nettype none
module rmq_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire rmq_pkg::in_t  din,
  output logic               full,
  output logic               mq_push,
  output rmq_pkg::term_t     mq_din,
  input  wire logic          mq_full
);
  import rmq_pkg::*;

  logic               f_v;
  in_t                f_m;
  logic               accept;
  logic signed [18:0] a00, a01, a02, a10, a11, a12, a20, a21, a22, tr, one_s;
  logic signed [18:0] t [4];
  branch_t            br;

  assign full    = f_v && mq_full;
  assign accept  = push && !full;
  assign mq_push = f_v && !mq_full;

  // hold the accepted word until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (accept) begin
      f_v <= 1'b1;
    end else if (mq_push) begin
      f_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) f_m <= din;
  end

  // widen entries and pick the branch
  always_comb begin
    a00 = 19'(f_m.m00); a01 = 19'(f_m.m01); a02 = 19'(f_m.m02);
    a10 = 19'(f_m.m10); a11 = 19'(f_m.m11); a12 = 19'(f_m.m12);
    a20 = 19'(f_m.m20); a21 = 19'(f_m.m21); a22 = 19'(f_m.m22);
    one_s = 19'(ONE);
    tr = a00 + a11 + a22;
    if (tr >= a00 && tr >= a11 && tr >= a22) br = BR_TRACE;
    else if (a00 >= a11 && a00 >= a22)      br = BR_X;
    else if (a11 >= a22)                    br = BR_Y;
    else                                    br = BR_Z;
  end

  // form the raw terms
  always_comb begin
    case (br)
      BR_TRACE: begin
        t[0] = a21 - a12; t[1] = a02 - a20; t[2] = a10 - a01; t[3] = one_s + tr;
      end
      BR_X: begin
        t[0] = one_s + a00 - a11 - a22; t[1] = a01 + a10;
        t[2] = a02 + a20;               t[3] = a21 - a12;
      end
      BR_Y: begin
        t[0] = a01 + a10;  t[1] = one_s - a00 + a11 - a22;
        t[2] = a12 + a21;  t[3] = a02 - a20;
      end
      default: begin
        t[0] = a02 + a20;  t[1] = a12 + a21;
        t[2] = one_s - a00 - a11 + a22; t[3] = a10 - a01;
      end
    endcase
  end

  // split into sign and magnitude
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mq_din.neg[i] = t[i][18];
      mq_din.mag[i] = MAG_W'(t[i][18] ? -t[i] : t[i]);
    end
  end
endmodule
`default_nettype wire

### sv/rmq_back.sv
// Back end: squared sum, pipelined square root, pipelined division, rounding.
// Depends on rmq_pkg.
`default_nettype none
module rmq_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           mq_empty,
  input  wire rmq_pkg::term_t mq_dout,
  output logic                mq_pop,
  output logic                ob_push,
  output rmq_pkg::out_t       ob_din,
  input  wire logic           ob_full
);
  import rmq_pkg::*;

  logic adv;

  // entry, squares, pair sums, total
  logic                 e_v, a_v, b_v, c_v;
  term_t                e_t, a_t, b_t, c_t;
  logic [SQ_W-1:0]      a_sq [4];
  logic [SQ_W:0]        b_p [2];
  logic [SUM_W-1:0]     c_s;

  // square root stages
  logic                 r_v    [ROOT_W+1];
  logic [REM_W-1:0]     r_rem  [ROOT_W+1];
  logic [ROOT_W-1:0]    r_root [ROOT_W+1];
  logic [VAL_W-1:0]     r_val  [ROOT_W+1];
  term_t                r_t    [ROOT_W+1];
  logic                 r_z    [ROOT_W+1];

  // division stages, four lanes
  logic                   d_v   [QUO_W+1];
  logic [ROOT_W:0]        d_d   [QUO_W+1];
  logic [3:0][REM_W-1:0]  d_rem [QUO_W+1];
  logic [3:0][QUO_W-1:0]  d_bits[QUO_W+1];
  logic [3:0][QUO_W-1:0]  d_q   [QUO_W+1];
  logic [3:0]             d_neg [QUO_W+1];
  logic                   d_z   [QUO_W+1];

  logic [NUM_W-1:0]     num [4];
  logic [QUO_W-1:0]     qs  [4];
  logic signed [15:0]   qo  [4];

  // stall everything only when the last word cannot leave
  assign adv     = !(d_v[QUO_W] && ob_full);
  assign ob_push = d_v[QUO_W] && !ob_full;
  assign mq_pop  = !mq_empty && adv;

  // valid bits of the front stages
  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0; a_v <= 1'b0; b_v <= 1'b0; c_v <= 1'b0;
    end else if (adv) begin
      e_v <= mq_pop; a_v <= e_v; b_v <= a_v; c_v <= b_v;
    end
  end

  // square, then add in a two-level tree
  always_ff @(posedge clk) begin
    if (adv) begin
      e_t <= mq_dout;
      for (int i = 0; i < 4; i++) a_sq[i] <= e_t.mag[i] * e_t.mag[i];
      a_t <= e_t;
      b_p[0] <= (SQ_W+1)'(a_sq[0]) + (SQ_W+1)'(a_sq[1]);
      b_p[1] <= (SQ_W+1)'(a_sq[2]) + (SQ_W+1)'(a_sq[3]);
      b_t <= a_t;
      c_s <= SUM_W'(b_p[0]) + SUM_W'(b_p[1]);
      c_t <= b_t;
    end
  end

  // root pipeline input
  assign r_v[0]    = c_v;
  assign r_rem[0]  = '0;
  assign r_root[0] = '0;
  assign r_val[0]  = {c_s, {(VAL_W-SUM_W){1'b0}}};
  assign r_t[0]    = c_t;
  assign r_z[0]    = (c_s == '0);

  // one root bit per stage
  for (genvar k = 0; k < ROOT_W; k++) begin : g_root
    logic [REM_W+1:0] rn, trial;
    logic             ge;
    assign rn    = {r_rem[k], r_val[k][VAL_W-1 -: 2]};
    assign trial = {2'b00, r_root[k], 2'b01};
    assign ge    = (rn >= trial);

    always_ff @(posedge clk) begin
      if (rst) r_v[k+1] <= 1'b0;
      else if (adv) r_v[k+1] <= r_v[k];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        r_rem[k+1]  <= ge ? REM_W'(rn - trial) : REM_W'(rn);
        r_root[k+1] <= {r_root[k][ROOT_W-2:0], ge};
        r_val[k+1]  <= {r_val[k][VAL_W-3:0], 2'b00};
        r_t[k+1]    <= r_t[k];
        r_z[k+1]    <= r_z[k];
      end
    end
  end

  // divider input: numerator |t|*2^27 + R, divisor 2R
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      num[i] = NUM_W'({r_t[ROOT_W].mag[i], 27'b0}) + NUM_W'(r_root[ROOT_W]);
    end
  end

  assign d_v[0]  = r_v[ROOT_W];
  assign d_d[0]  = {r_root[ROOT_W], 1'b0};
  assign d_neg[0] = r_t[ROOT_W].neg;
  assign d_z[0]  = r_z[ROOT_W];
  for (genvar i = 0; i < 4; i++) begin : g_dinit
    assign d_rem[0][i]  = REM_W'(num[i][NUM_W-1:QUO_W]);
    assign d_bits[0][i] = num[i][QUO_W-1:0];
    assign d_q[0][i]    = '0;
  end

  // one quotient bit per stage in each lane
  for (genvar j = 0; j < QUO_W; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) d_v[j+1] <= 1'b0;
      else if (adv) d_v[j+1] <= d_v[j];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        d_d[j+1]   <= d_d[j];
        d_neg[j+1] <= d_neg[j];
        d_z[j+1]   <= d_z[j];
      end
    end

    for (genvar i = 0; i < 4; i++) begin : g_lane
      logic [REM_W:0] r2;
      logic           ge;
      assign r2 = {d_rem[j][i], d_bits[j][i][QUO_W-1]};
      assign ge = (r2 >= (REM_W+1)'(d_d[j]));

      always_ff @(posedge clk) begin
        if (adv) begin
          d_rem[j+1][i]  <= ge ? REM_W'(r2 - (REM_W+1)'(d_d[j])) : REM_W'(r2);
          d_bits[j+1][i] <= {d_bits[j][i][QUO_W-2:0], 1'b0};
          d_q[j+1][i]    <= {d_q[j][i][QUO_W-2:0], ge};
        end
      end
    end
  end

  // saturate, apply sign, force zero on an empty sum
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qs[i] = (d_q[QUO_W][i] > QUO_W'(QMAX)) ? QUO_W'(QMAX) : d_q[QUO_W][i];
      if (d_z[QUO_W]) qo[i] = '0;
      else            qo[i] = d_neg[QUO_W][i] ? -16'(qs[i]) : 16'(qs[i]);
    end
    ob_din.q_x        = qo[0];
    ob_din.q_y        = qo[1];
    ob_din.q_z        = qo[2];
    ob_din.q_w        = qo[3];
    ob_din.degenerate = d_z[QUO_W];
  end
endmodule
`default_nettype wire

### sv/rotation_matrix_to_quaternion_unit.sv
// Top level of the rotation matrix to quaternion unit.
// Depends on rmq_pkg, rmq_fifo, rmq_front, rmq_back and the defines header.
`default_nettype none
`include "rotation_matrix_to_quaternion_unit_defines.svh"
// Converts a Q2.14 rotation matrix to a Q2.14 quaternion (x, y, z, w) by
// Shepperd's method, one matrix per clock sustained while the result side does
// not stall. From the accepting edge until empty drops, a matrix passes the
// middle and output queue writes, the entry, squares, pair sums and total
// registers for the squared sum, 30 square root stages (one root bit each)
// and 16 divider stages (one quotient bit each). The result side is a small
// queue, so a matrix is taken while a finished quaternion waits to be popped.
module rotation_matrix_to_quaternion_unit #(
  parameter int QUEUE_DEPTH = rmq_pkg::QUEUE_DEPTH_DEF,
  parameter int OUT_DEPTH   = rmq_pkg::OUT_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire rmq_pkg::in_t  din,
  output logic               full,
  input  wire logic          pop,
  output rmq_pkg::out_t      dout,
  output logic               empty
);
  import rmq_pkg::*;

  logic  mq_push, mq_full, mq_pop, mq_empty, ob_push, ob_full;
  term_t mq_din, mq_dout;
  out_t  ob_din;
  logic  q_all_zero;

  rmq_front u_front (
    .clk, .rst, .push, .din, .full,
    .mq_push, .mq_din, .mq_full
  );

  rmq_fifo #(.W($bits(term_t)), .DEPTH(QUEUE_DEPTH)) u_mid_q (
    .clk, .rst, .push(mq_push), .din(mq_din), .full(mq_full),
    .pop(mq_pop), .dout(mq_dout), .empty(mq_empty)
  );

  rmq_back u_back (
    .clk, .rst, .mq_empty, .mq_dout, .mq_pop,
    .ob_push, .ob_din, .ob_full
  );

  rmq_fifo #(.W($bits(out_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk, .rst, .push(ob_push), .din(ob_din), .full(ob_full),
    .pop, .dout, .empty
  );

  // all four components of the head word are zero
  assign q_all_zero = (dout.q_x == 0) && (dout.q_y == 0) && (dout.q_z == 0) && (dout.q_w == 0);

  `RMQ_ASSERT_NOW(a_degen_zero, !empty && dout.degenerate, q_all_zero)
  `RMQ_ASSERT_NOW(a_w_range, !empty, dout.q_w <= 16'sd16384 && dout.q_w >= -16'sd16384)
  `RMQ_ASSERT_NOW(a_no_overflow, ob_push, !ob_full)
  `RMQ_ASSERT_NEXT(a_mid_taken, mq_push && !mq_full, !mq_empty)
endmodule
`default_nettype wire

### tb/tb_top.sv
// Testbench for the rotation matrix to quaternion unit: drives matrices through
// the push side and checks each popped quaternion against a built-in predictor.
// Depends on rmq_pkg and rotation_matrix_to_quaternion_unit.
`timescale 1ns / 1ps
module tb_top;
  import rmq_pkg::*;

  localparam int LATENCY     = 52;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_CNT  = 1330;

  logic clk;
  logic rst;
  logic push;
  in_t  din;
  logic full;
  logic pop;
  out_t dout;
  logic empty;

  in_t  pending_matrices[$];
  out_t expected_quats[$];
  int   error_count;
  int   accepted_count;
  int   popped_count;
  int   degenerate_count;
  int   branch_count[4];
  int   idle_cycles;
  int   send_wait;
  int   recv_wait;
  bit   hold_sender;
  logic full_at_edge;
  logic empty_at_edge;

  rotation_matrix_to_quaternion_unit DUT (
    .clk(clk), .rst(rst), .push(push), .din(din), .full(full),
    .pop(pop), .dout(dout), .empty(empty)
  );

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // Integer square root, bit by bit
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Scale one raw term by the root with round-half-away and saturation
  function automatic logic signed [15:0] scale_quat_term(input longint t,
                                                         input longint unsigned root);
    longint unsigned mag;
    longint unsigned q;
    mag = (t < 0) ? -t : t;
    q = ((mag << 27) + root) / (root * 2);
    if (q > QMAX) q = QMAX;
    return 16'((t < 0) ? -q : q);
  endfunction

  // Shepperd selection, raw terms, normalization
  function automatic out_t predict_quat(input in_t m, output branch_t br);
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22, tr;
    longint t[4];
    longint unsigned sum;
    longint unsigned root;
    out_t r;
    a00 = m.m00; a01 = m.m01; a02 = m.m02;
    a10 = m.m10; a11 = m.m11; a12 = m.m12;
    a20 = m.m20; a21 = m.m21; a22 = m.m22;
    tr = a00 + a11 + a22;
    if (tr >= a00 && tr >= a11 && tr >= a22) begin
      br = BR_TRACE;
      t[0] = a21 - a12; t[1] = a02 - a20; t[2] = a10 - a01; t[3] = ONE + tr;
    end else if (a00 >= a11 && a00 >= a22) begin
      br = BR_X;
      t[0] = ONE - tr + 2 * a00; t[1] = a01 + a10; t[2] = a02 + a20; t[3] = a21 - a12;
    end else if (a11 >= a22) begin
      br = BR_Y;
      t[0] = a01 + a10; t[1] = ONE - tr + 2 * a11; t[2] = a12 + a21; t[3] = a02 - a20;
    end else begin
      br = BR_Z;
      t[0] = a02 + a20; t[1] = a12 + a21; t[2] = ONE - tr + 2 * a22; t[3] = a10 - a01;
    end
    sum = 0;
    for (int i = 0; i < 4; i++) sum += t[i] * t[i];
    r = '0;
    if (sum == 0) begin
      r.degenerate = 1'b1;
    end else begin
      root = int_sqrt(sum << 24);
      r.q_x = scale_quat_term(t[0], root);
      r.q_y = scale_quat_term(t[1], root);
      r.q_z = scale_quat_term(t[2], root);
      r.q_w = scale_quat_term(t[3], root);
    end
    return r;
  endfunction

  function automatic logic signed [15:0] rand_entry();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 16'sh7fff;
    if (sel == 1) return 16'sh8000;
    if (sel < 5) return 16'($urandom_range(0, 32768) - 16384);
    return 16'($urandom());
  endfunction

  // Rotation about a random axis-aligned permutation by a random angle,
  // plus small noise, so every branch is reached with plausible matrices
  function automatic in_t rand_rotation();
    in_t m;
    logic signed [15:0] e[9];
    int perm[3];
    int k;
    real ang, c, s;
    perm = '{0, 1, 2};
    for (int i = 2; i > 0; i--) begin
      int j, tmp;
      j = $urandom_range(0, i);
      tmp = perm[i]; perm[i] = perm[j]; perm[j] = tmp;
    end
    ang = ($urandom_range(0, 62831) / 10000.0);
    c = $cos(ang);
    s = $sin(ang);
    for (int i = 0; i < 9; i++) e[i] = 0;
    k = $urandom_range(0, 2);
    // planar rotation in the two axes other than k
    for (int r = 0; r < 3; r++) begin
      for (int cc = 0; cc < 3; cc++) begin
        real v;
        if (r == k || cc == k) v = (r == cc) ? 1.0 : 0.0;
        else if (r == cc) v = c;
        else v = (r < cc) ? -s : s;
        e[3 * perm[r] + perm[cc]] =
          16'($rtoi(v * 16384.0) + $signed($urandom_range(0, 6)) - 3);
      end
    end
    m.m00 = e[0]; m.m01 = e[1]; m.m02 = e[2];
    m.m10 = e[3]; m.m11 = e[4]; m.m12 = e[5];
    m.m20 = e[6]; m.m21 = e[7]; m.m22 = e[8];
    return m;
  endfunction

  function automatic in_t diag_matrix(input int d0, input int d1, input int d2);
    in_t m;
    m = '0;
    m.m00 = 16'(d0); m.m11 = 16'(d1); m.m22 = 16'(d2);
    return m;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on word %0d: %s got %0d expected %0d", popped_count, what, got, want);
    error_count++;
  endtask

  // Driver: present words from the pending queue, idle at random
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (push && !full_at_edge) begin
      // word taken at the last rising edge
      if (send_wait == 0 && !hold_sender && pending_matrices.size() > 0) begin
        din <= pending_matrices.pop_front();
        send_wait = $urandom_range(0, 4);
      end else begin
        push <= 1'b0;
      end
    end else if (!push) begin
      if (send_wait > 0) send_wait--;
      else if (!hold_sender && pending_matrices.size() > 0) begin
        din  <= pending_matrices.pop_front();
        push <= 1'b1;
        send_wait = $urandom_range(0, 4);
      end
    end
  end

  // Sample full at the rising edge so the driver knows whether the word went
  always @(posedge clk) full_at_edge <= full;

  // Monitor: predict on accept, check on pop, watch for a stall
  always @(posedge clk) begin
    branch_t br;
    out_t exp_q;
    bit moved;
    moved = 1'b0;
    if (!rst) begin
      if (push && !full) begin
        exp_q = predict_quat(din, br);
        expected_quats.push_back(exp_q);
        branch_count[br]++;
        accepted_count++;
        moved = 1'b1;
      end
      if (pop && !empty) begin
        moved = 1'b1;
        if (expected_quats.size() == 0) begin
          $display("unexpected word popped: %h", dout);
          error_count++;
        end else begin
          exp_q = expected_quats.pop_front();
          if (dout.q_x !== exp_q.q_x) report_mismatch("q_x", dout.q_x, exp_q.q_x);
          if (dout.q_y !== exp_q.q_y) report_mismatch("q_y", dout.q_y, exp_q.q_y);
          if (dout.q_z !== exp_q.q_z) report_mismatch("q_z", dout.q_z, exp_q.q_z);
          if (dout.q_w !== exp_q.q_w) report_mismatch("q_w", dout.q_w, exp_q.q_w);
          if (dout.degenerate !== exp_q.degenerate)
            report_mismatch("degenerate", dout.degenerate, exp_q.degenerate);
          if (exp_q.degenerate) degenerate_count++;
        end
        popped_count++;
      end
      if (moved) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no word moved in %0d cycles", STALL_LIMIT);
        $display("tb_top failed");
        $finish;
      end
    end
  end

  // Receiver: random stalls between pops
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (recv_wait > 0) begin
      recv_wait--;
      pop <= 1'b0;
    end else if (pop && !empty_at_edge) begin
      recv_wait = $urandom_range(0, 4);
      if (recv_wait == 0) pop <= 1'b1;
      else pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) empty_at_edge <= empty;

  initial begin
    in_t m;
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    din = '0;
    error_count = 0;
    accepted_count = 0;
    popped_count = 0;
    degenerate_count = 0;
    branch_count = '{0, 0, 0, 0};
    idle_cycles = 0;
    send_wait = 0;
    recv_wait = 0;
    hold_sender = 1'b0;
    full_at_edge = 1'b0;
    empty_at_edge = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: identity, each branch, ties, extremes of the fields
    pending_matrices.push_back(diag_matrix(ONE, ONE, ONE));
    pending_matrices.push_back(diag_matrix(ONE, -ONE, -ONE));
    pending_matrices.push_back(diag_matrix(-ONE, ONE, -ONE));
    pending_matrices.push_back(diag_matrix(-ONE, -ONE, ONE));
    pending_matrices.push_back(diag_matrix(-ONE, -ONE, -ONE));
    pending_matrices.push_back(diag_matrix(0, 0, -5));
    pending_matrices.push_back(diag_matrix(-3, -3, -3));
    pending_matrices.push_back(diag_matrix(-2, -2, -7));
    pending_matrices.push_back(diag_matrix(-7, -2, -2));
    pending_matrices.push_back(diag_matrix(0, 0, 0));
    m = '{default: 16'sh7fff};
    pending_matrices.push_back(m);
    m = '{default: 16'sh8000};
    pending_matrices.push_back(m);
    m = '{m00: 16'sh8000, m01: 16'sh7fff, m02: 16'sh8000, m10: 16'sh8000, m11: 16'sh7fff,
          m12: 16'sh7fff, m20: 16'sh7fff, m21: 16'sh8000, m22: 16'sh8000};
    pending_matrices.push_back(m);
    m = '{m00: 16'sh8000, m01: 16'sh8000, m02: 16'sh7fff, m10: 16'sh7fff, m11: 16'sh8000,
          m12: 16'sh8000, m20: 16'sh8000, m21: 16'sh7fff, m22: 16'sh8000};
    pending_matrices.push_back(m);
    m = '{m00: 16'sh8000, m01: 16'sh0001, m02: 16'shffff, m10: 16'sh0000, m11: 16'sh8000,
          m12: 16'sh5555, m20: 16'shaaaa, m21: 16'sh0000, m22: 16'sh7fff};
    pending_matrices.push_back(m);
    for (int i = 0; i < 6; i++) pending_matrices.push_back(rand_rotation());

    // Pause the sender until every expected word has come back
    wait (pending_matrices.size() == 0 && !push);
    hold_sender = 1'b1;
    wait (expected_quats.size() == 0);
    @(negedge clk);
    hold_sender = 1'b0;

    // Random: mostly rotations, some raw noise
    for (int i = 0; i < RANDOM_CNT; i++) begin
      if ($urandom_range(0, 3) != 0) begin
        m = rand_rotation();
      end else begin
        m.m00 = rand_entry(); m.m01 = rand_entry(); m.m02 = rand_entry();
        m.m10 = rand_entry(); m.m11 = rand_entry(); m.m12 = rand_entry();
        m.m20 = rand_entry(); m.m21 = rand_entry(); m.m22 = rand_entry();
      end
      pending_matrices.push_back(m);
    end

    wait (pending_matrices.size() == 0 && !push);
    wait (expected_quats.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    $display("accepted %0d matrices, popped %0d quaternions, %0d degenerate",
             accepted_count, popped_count, degenerate_count);
    $display("branches: trace %0d, x %0d, y %0d, z %0d", branch_count[0],
             branch_count[1], branch_count[2], branch_count[3]);
    if (error_count == 0 && expected_quats.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule

### filelist.f
+incdir+sv
sv/rmq_pkg.sv
sv/rmq_fifo.sv
sv/rmq_front.sv
sv/rmq_back.sv
sv/rotation_matrix_to_quaternion_unit.sv
tb/tb_top.sv
